// ===== design/espnow_sender_table_logger_unit_macros.svh =====
//------------------------------------------------------------------------------
// Sender table logger assertion macros
// Clocked assertion helpers used by the logger RTL.
//------------------------------------------------------------------------------
`ifndef ESPNOW_SENDER_TABLE_LOGGER_UNIT_MACROS_SVH
`define ESPNOW_SENDER_TABLE_LOGGER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ESL_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ESL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ESL_ASSERT_SAME(label, ante, cons)
`define ESL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/esl_pkg.sv =====
//------------------------------------------------------------------------------
// Sender table logger package
// Shared widths, filter constants, codes and records.
//------------------------------------------------------------------------------
package esl_pkg;

	localparam int TABLE_ENTRIES = 4;
	localparam int HIST_DEPTH    = 512;

	localparam int IDX_W   = 2;
	localparam int CNT_W   = 3;
	localparam int HIST_AW = $clog2(HIST_DEPTH);
	localparam int HIST_CW = $clog2(HIST_DEPTH + 1);
	localparam int HP_W    = HIST_CW + 1;
	localparam int POS_W   = 9;
	localparam int MAC_W   = 48;
	localparam int TIME_W  = 32;
	localparam int STR_W   = 8;

	localparam logic [11:0] MIN_LENGTH = 12'd28;
	localparam logic [7:0]  FC_ACTION  = 8'hD0;
	localparam logic [7:0]  CAT_VENDOR = 8'h7F;
	localparam logic [23:0] VENDOR_OUI = 24'h18FE34;

	typedef enum logic [1:0] {
		MODE_FRAME      = 2'd0,
		MODE_CLEAR      = 2'd1,
		MODE_READ_HIST  = 2'd2,
		MODE_READ_ENTRY = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_FILTERED = 3'd0,
		ST_KNOWN    = 3'd1,
		ST_NEW      = 3'd2,
		ST_FULL     = 3'd3,
		ST_CLEARED  = 3'd4,
		ST_RECORD   = 3'd5,
		ST_RANGE    = 3'd6,
		ST_ENTRY    = 3'd7
	} status_t;

	typedef struct packed {
		logic [TIME_W-1:0] rtime;
		logic [IDX_W-1:0]  sender;
		logic [STR_W-1:0]  strength;
	} hist_rec_t;

	typedef struct packed {
		status_t           status;
		logic [IDX_W-1:0]  sidx;
		logic [CNT_W-1:0]  count;
		logic              log_en;
		logic [TIME_W-1:0] entry_time;
		logic [STR_W-1:0]  entry_strength;
		logic [MAC_W-1:0]  entry_mac;
	} tbl_res_t;

endpackage

// ===== design/espnow_sender_table_logger_unit.sv =====
//------------------------------------------------------------------------------
// Sender table logger
// Filters sniffed vendor action frames, tracks senders and logs a history.
//------------------------------------------------------------------------------
// Input channel: one word per frame summary or command (mode), taken when
// in_valid is high and in_stall is low. Output channel: exactly one result
// word per input word, in order, taken when out_valid is high and out_stall
// is low.
// The word is registered in the input register, then the filter, table
// lookup, history ring access and all state updates are done in one pass
// into the result register; history read data comes from the ring memory's
// registered read port at the same edge.
// Throughput is one word per cycle while out_stall is low; each word makes
// at most one ring write or one ring read.
// When out_stall is high the result holds and one more word may be taken
// into the input register; after that in_stall rises until the result moves.
// Reset empties the sender table and the history (head and fill to zero);
// the ring memory is not cleared; a record is reported only below the fill.
//------------------------------------------------------------------------------
`include "espnow_sender_table_logger_unit_macros.svh"

module espnow_sender_table_logger_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic               is_management,
	input  logic [11:0]        frame_length,
	input  logic [7:0]         frame_control,
	input  logic [7:0]         action_category,
	input  logic [23:0]        vendor_oui,
	input  logic [47:0]        source_mac,
	input  logic signed [7:0]  signal_strength,
	input  logic [31:0]        timestamp,
	input  logic [8:0]         read_position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [1:0]         sender_index,
	output logic [2:0]         sender_count,
	output logic [9:0]         history_count,
	output logic [31:0]        record_time,
	output logic [1:0]         record_sender,
	output logic signed [7:0]  record_strength,
	output logic [47:0]        entry_mac
);

	logic                       v_s1;
	esl_pkg::mode_t             mode_s1;
	logic                       mgmt_s1;
	logic [11:0]                len_s1;
	logic [7:0]                 fc_s1;
	logic [7:0]                 cat_s1;
	logic [23:0]                oui_s1;
	logic [esl_pkg::MAC_W-1:0]  mac_s1;
	logic [esl_pkg::STR_W-1:0]  str_s1;
	logic [esl_pkg::TIME_W-1:0] time_s1;
	logic [esl_pkg::POS_W-1:0]  pos_s1;

	logic                        v_s2;
	esl_pkg::status_t            status_s2;
	logic [esl_pkg::IDX_W-1:0]   sidx_s2;
	logic [esl_pkg::CNT_W-1:0]   scount_s2;
	logic [esl_pkg::HIST_CW-1:0] hcount_s2;
	logic [esl_pkg::TIME_W-1:0]  etime_s2;
	logic [esl_pkg::STR_W-1:0]   estr_s2;
	logic [esl_pkg::MAC_W-1:0]   emac_s2;

	logic                        adv;
	logic                        fire;
	logic                        in_take;
	esl_pkg::tbl_res_t           tbl;
	esl_pkg::hist_rec_t          rec;
	esl_pkg::hist_rec_t          hist_rd_s2;
	logic                        hist_hit;
	logic [esl_pkg::HIST_CW-1:0] hist_count;
	esl_pkg::status_t            status_d;

	assign adv      = !v_s2 || !out_stall;
	assign fire     = v_s1 && adv;
	assign in_stall = v_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_take) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_s1 <= esl_pkg::mode_t'(mode);
			mgmt_s1 <= is_management;
			len_s1  <= frame_length;
			fc_s1   <= frame_control;
			cat_s1  <= action_category;
			oui_s1  <= vendor_oui;
			mac_s1  <= source_mac;
			str_s1  <= signal_strength;
			time_s1 <= timestamp;
			pos_s1  <= read_position;
		end
	end

	esl_sender_table u_table (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.mode            (mode_s1),
		.is_management   (mgmt_s1),
		.frame_length    (len_s1),
		.frame_control   (fc_s1),
		.action_category (cat_s1),
		.vendor_oui      (oui_s1),
		.source_mac      (mac_s1),
		.strength        (str_s1),
		.now             (time_s1),
		.read_position   (pos_s1),
		.res             (tbl)
	);

	always_comb begin
		rec.rtime    = time_s1;
		rec.sender   = tbl.sidx;
		rec.strength = str_s1;
	end

	esl_history u_history (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.mode          (mode_s1),
		.log_en        (tbl.log_en),
		.rec           (rec),
		.read_position (pos_s1),
		.in_range      (hist_hit),
		.count         (hist_count),
		.rd_s2         (hist_rd_s2)
	);

	always_comb begin
		status_d = tbl.status;
		if (mode_s1 == esl_pkg::MODE_READ_HIST) begin
			status_d = hist_hit ? esl_pkg::ST_RECORD : esl_pkg::ST_RANGE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (fire) begin
			v_s2 <= 1'b1;
		end else if (!out_stall) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s2 <= status_d;
			sidx_s2   <= tbl.sidx;
			scount_s2 <= tbl.count;
			hcount_s2 <= hist_count;
			etime_s2  <= tbl.entry_time;
			estr_s2   <= tbl.entry_strength;
			emac_s2   <= tbl.entry_mac;
		end
	end

	always_comb begin
		out_valid     = v_s2;
		status        = status_s2;
		sender_index  = sidx_s2;
		sender_count  = scount_s2;
		history_count = hcount_s2;
		entry_mac     = emac_s2;
		if (status_s2 == esl_pkg::ST_RECORD) begin
			record_time     = hist_rd_s2.rtime;
			record_sender   = hist_rd_s2.sender;
			record_strength = $signed(hist_rd_s2.strength);
		end else begin
			record_time     = etime_s2;
			record_sender   = '0;
			record_strength = $signed(estr_s2);
		end
	end

	`ESL_ASSERT_SAME(a_count_bound, out_valid, sender_count <= 3'd4)
	`ESL_ASSERT_SAME(a_entry_index, out_valid && status == esl_pkg::ST_ENTRY,
		{1'b0, sender_index} < sender_count)
	`ESL_ASSERT_SAME(a_logged_nonempty,
		out_valid && (status == esl_pkg::ST_KNOWN || status == esl_pkg::ST_NEW),
		history_count != 10'd0 && sender_count != 3'd0)
	`ESL_ASSERT_SAME(a_cleared_empty, out_valid && status == esl_pkg::ST_CLEARED,
		sender_count == 3'd0 && history_count == 10'd0)
	`ESL_ASSERT_NEXT(a_result_held, out_valid && out_stall,
		out_valid && $stable(status) && $stable(record_time))

endmodule

// ===== design/esl_sender_table.sv =====
//------------------------------------------------------------------------------
// Sender table
// Frame filter, sender MAC lookup and append, per-sender last RSSI and time.
//------------------------------------------------------------------------------
module esl_sender_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  esl_pkg::mode_t             mode,
	input  logic                       is_management,
	input  logic [11:0]                frame_length,
	input  logic [7:0]                 frame_control,
	input  logic [7:0]                 action_category,
	input  logic [23:0]                vendor_oui,
	input  logic [esl_pkg::MAC_W-1:0]  source_mac,
	input  logic [esl_pkg::STR_W-1:0]  strength,
	input  logic [esl_pkg::TIME_W-1:0] now,
	input  logic [esl_pkg::POS_W-1:0]  read_position,
	output esl_pkg::tbl_res_t          res
);

	logic [esl_pkg::MAC_W-1:0]  mac_q  [esl_pkg::TABLE_ENTRIES];
	logic [esl_pkg::STR_W-1:0]  str_q  [esl_pkg::TABLE_ENTRIES];
	logic [esl_pkg::TIME_W-1:0] seen_q [esl_pkg::TABLE_ENTRIES];
	logic [esl_pkg::CNT_W-1:0]  total_q;

	logic                      passes;
	logic                      hit;
	logic [esl_pkg::IDX_W-1:0] hit_idx;
	logic [esl_pkg::IDX_W-1:0] pos_idx;
	logic                      pos_ok;
	logic                      append;

	always_comb begin
		passes = (mode == esl_pkg::MODE_FRAME) && is_management
			&& (frame_length >= esl_pkg::MIN_LENGTH)
			&& (frame_control == esl_pkg::FC_ACTION)
			&& (action_category == esl_pkg::CAT_VENDOR)
			&& (vendor_oui == esl_pkg::VENDOR_OUI);
		hit = 1'b0;
		hit_idx = '0;
		for (int i = esl_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
			if ((esl_pkg::CNT_W'(i) < total_q) && (mac_q[i] == source_mac)) begin
				hit = 1'b1;
				hit_idx = esl_pkg::IDX_W'(i);
			end
		end
		pos_idx = read_position[esl_pkg::IDX_W-1:0];
		pos_ok = read_position < esl_pkg::POS_W'(total_q);
		append = 1'b0;

		res = '0;
		res.count = total_q;
		res.status = esl_pkg::ST_RANGE;
		case (mode)
			esl_pkg::MODE_FRAME: begin
				res.status = esl_pkg::ST_FILTERED;
				if (passes) begin
					if (hit) begin
						res.status = esl_pkg::ST_KNOWN;
						res.sidx = hit_idx;
						res.log_en = 1'b1;
					end else if (total_q < esl_pkg::CNT_W'(esl_pkg::TABLE_ENTRIES)) begin
						res.status = esl_pkg::ST_NEW;
						res.sidx = total_q[esl_pkg::IDX_W-1:0];
						res.log_en = 1'b1;
						res.count = total_q + 1'b1;
						append = 1'b1;
					end else begin
						res.status = esl_pkg::ST_FULL;
					end
				end
			end
			esl_pkg::MODE_CLEAR: begin
				res.status = esl_pkg::ST_CLEARED;
				res.count = '0;
			end
			esl_pkg::MODE_READ_ENTRY: begin
				if (pos_ok) begin
					res.status = esl_pkg::ST_ENTRY;
					res.sidx = pos_idx;
					res.entry_time = seen_q[pos_idx];
					res.entry_strength = str_q[pos_idx];
					res.entry_mac = mac_q[pos_idx];
				end
			end
			default: res.status = esl_pkg::ST_RANGE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			for (int i = 0; i < esl_pkg::TABLE_ENTRIES; i++) begin
				mac_q[i]  <= '0;
				str_q[i]  <= '0;
				seen_q[i] <= '0;
			end
		end else if (fire) begin
			if (mode == esl_pkg::MODE_CLEAR) begin
				total_q <= '0;
				for (int i = 0; i < esl_pkg::TABLE_ENTRIES; i++) begin
					mac_q[i]  <= '0;
					str_q[i]  <= '0;
					seen_q[i] <= '0;
				end
			end else if (res.log_en) begin
				total_q <= res.count;
				str_q[res.sidx]  <= strength;
				seen_q[res.sidx] <= now;
				if (append) begin
					mac_q[res.sidx] <= source_mac;
				end
			end
		end
	end

endmodule

// ===== design/esl_history.sv =====
//------------------------------------------------------------------------------
// History ring
// Ring memory of logged records with head pointer and saturating fill count.
//------------------------------------------------------------------------------
module esl_history (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  esl_pkg::mode_t              mode,
	input  logic                        log_en,
	input  esl_pkg::hist_rec_t          rec,
	input  logic [esl_pkg::POS_W-1:0]   read_position,
	output logic                        in_range,
	output logic [esl_pkg::HIST_CW-1:0] count,
	output esl_pkg::hist_rec_t          rd_s2
);

	esl_pkg::hist_rec_t mem [esl_pkg::HIST_DEPTH];

	logic [esl_pkg::HIST_AW-1:0] head_q;
	logic [esl_pkg::HIST_CW-1:0] fill_q;
	logic [esl_pkg::HP_W-1:0]    start_w;
	logic [esl_pkg::HP_W-1:0]    at_w;
	logic [esl_pkg::HIST_AW-1:0] at;
	logic [esl_pkg::HIST_AW-1:0] head_inc;
	logic                        wr_en;
	logic                        rd_en;

	localparam logic [esl_pkg::HP_W-1:0] DEPTH_W = esl_pkg::HP_W'(esl_pkg::HIST_DEPTH);

	always_comb begin
		start_w = esl_pkg::HP_W'(head_q) + DEPTH_W - esl_pkg::HP_W'(fill_q);
		if (start_w >= DEPTH_W) begin
			start_w = start_w - DEPTH_W;
		end
		at_w = start_w + esl_pkg::HP_W'(read_position);
		if (at_w >= DEPTH_W) begin
			at_w = at_w - DEPTH_W;
		end
		at = at_w[esl_pkg::HIST_AW-1:0];
		in_range = esl_pkg::HP_W'(read_position) < esl_pkg::HP_W'(fill_q);

		if (esl_pkg::HP_W'(head_q) + 1'b1 == DEPTH_W) begin
			head_inc = '0;
		end else begin
			head_inc = head_q + 1'b1;
		end

		wr_en = fire && (mode == esl_pkg::MODE_FRAME) && log_en;
		rd_en = fire && (mode == esl_pkg::MODE_READ_HIST);

		count = fill_q;
		if (mode == esl_pkg::MODE_CLEAR) begin
			count = '0;
		end else if (mode == esl_pkg::MODE_FRAME && log_en
				&& fill_q != esl_pkg::HIST_CW'(esl_pkg::HIST_DEPTH)) begin
			count = fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (fire) begin
			fill_q <= count;
			if (mode == esl_pkg::MODE_CLEAR) begin
				head_q <= '0;
			end else if (wr_en) begin
				head_q <= head_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[head_q] <= rec;
		end
		if (rd_en) begin
			rd_s2 <= mem[at];
		end
	end

endmodule
